FILE: hw/rtl/pqca_pkg.sv
// ----------------------------------------------------------------------------
// pqca_pkg
// Shared types and constants of the frequency constraint aggregator.
// ----------------------------------------------------------------------------
package pqca_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int FREQ_BITS = 32;
  localparam int IDX_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [2:0] ACT_ADD_MIN = 3'd0;
  localparam logic [2:0] ACT_ADD_MAX = 3'd1;
  localparam logic [2:0] ACT_UPDATE  = 3'd2;
  localparam logic [2:0] ACT_REM_MIN = 3'd3;
  localparam logic [2:0] ACT_REM_MAX = 3'd4;
  localparam logic [2:0] ACT_CHECK   = 3'd5;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MIN  = 2'd1,
    KIND_MAX  = 2'd2
  } kind_t;

  typedef logic [FREQ_BITS-1:0] freq_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  typedef struct packed {
    kind_t kind;
    freq_t freq;
  } entry_t;

  typedef struct packed {
    logic  min_valid;
    freq_t min_freq;
    logic  max_valid;
    freq_t max_freq;
  } bounds_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [31:0] frequency;
  } in_item_t;

  typedef struct packed {
    logic        min_valid;
    logic [31:0] min_freq;
    logic        max_valid;
    logic [31:0] max_freq;
    logic        conflict;
    logic        allowed;
  } out_item_t;

endpackage

FILE: hw/rtl/pstate_qos_constraint_aggregator_top.sv
// ----------------------------------------------------------------------------
// pstate_qos_constraint_aggregator_top
// Frequency constraint aggregator: slot table, rescan and check.
// ----------------------------------------------------------------------------
// The addressed slot is read at the edge that accepts the item, the update
// state writes it back, the scan state rescans every slot through the single
// read port, the drain state takes the last read and the finish state forms
// conflict and the check answer. The block returns to idle before it takes
// the next item, so it takes no new item while one is still in flight.
// A new item is taken once the result has moved into the output register;
// the result then waits there while the next item runs. The slot table needs
// no clearing pass after reset.
module pstate_qos_constraint_aggregator_top
  import pqca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MODIFY = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t   state;
  state_t   state_next;
  in_item_t item;
  idx_t     cnt;
  logic     scan_rd_valid;
  logic     in_range;
  freq_t    freq;

  logic     we;
  entry_t   wdata;
  idx_t     raddr;
  entry_t   rdata;
  bounds_t  bounds;
  logic     conflict;
  logic     allowed;
  logic     accept;
  logic     load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign load_out = (state == ST_FINISH) && (!out_valid || !out_stall);
  assign in_range = (32'(item.slot) < NUM_SLOTS);
  assign freq     = FREQ_BITS'(item.frequency);

  always_comb begin
    raddr = cnt;
    if (state == ST_IDLE) begin
      raddr = IDX_BITS'(in_item.slot);
    end
  end

  // Read-modify-write of the addressed slot.
  always_comb begin
    wdata = rdata;
    we    = 1'b0;
    case (item.action)
      ACT_ADD_MIN: begin
        we         = 1'b1;
        wdata.freq = freq;
        wdata.kind = KIND_MIN;
      end
      ACT_ADD_MAX: begin
        we         = 1'b1;
        wdata.freq = freq;
        wdata.kind = KIND_MAX;
      end
      ACT_UPDATE: begin
        we         = (rdata.kind != KIND_NONE);
        wdata.freq = freq;
      end
      ACT_REM_MIN: begin
        we         = (rdata.kind == KIND_MIN);
        wdata.kind = KIND_NONE;
      end
      ACT_REM_MAX: begin
        we         = (rdata.kind == KIND_MAX);
        wdata.kind = KIND_NONE;
      end
      default: begin
        we = 1'b0;
      end
    endcase
    we = we && in_range && (state == ST_MODIFY);
  end

  pqca_slot_table u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (we),
    .waddr (IDX_BITS'(item.slot)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pqca_minmax_acc u_acc (
    .clk    (clk),
    .rst    (rst),
    .clear  (state == ST_MODIFY),
    .en     (scan_rd_valid),
    .entry  (rdata),
    .bounds (bounds)
  );

  assign conflict = bounds.min_valid && bounds.max_valid
                    && (bounds.min_freq > bounds.max_freq);
  assign allowed  = (item.action == ACT_CHECK) && !conflict
                    && !(bounds.min_valid && freq < bounds.min_freq)
                    && !(bounds.max_valid && freq > bounds.max_freq);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_MODIFY;
      ST_MODIFY: state_next = ST_SCAN;
      ST_SCAN:   if (cnt == IDX_BITS'(NUM_SLOTS - 1)) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      scan_rd_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      scan_rd_valid <= (state == ST_SCAN);
      if (state == ST_SCAN) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
    if (load_out) begin
      out_item.min_valid <= bounds.min_valid;
      out_item.min_freq  <= 32'(bounds.min_freq);
      out_item.max_valid <= bounds.max_valid;
      out_item.max_freq  <= 32'(bounds.max_freq);
      out_item.conflict  <= conflict;
      out_item.allowed   <= allowed;
    end
  end

  a_accept_to_modify: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_MODIFY)
    else $error("accepted item did not move to slot update");

  a_write_only_in_modify: assert property (@(posedge clk) disable iff (rst)
    we |-> state == ST_MODIFY && in_range)
    else $error("slot table written outside update");

  a_conflict_needs_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.conflict |-> out_item.min_valid && out_item.max_valid)
    else $error("conflict without both bounds");

  a_allowed_no_conflict: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.allowed |-> !out_item.conflict)
    else $error("check passed under conflict");

endmodule

FILE: hw/rtl/pqca_slot_table.sv
// ----------------------------------------------------------------------------
// pqca_slot_table
// Slot table memory, one write and one registered read port. Per-entry
// valid bits make a never-written entry read as kind none.
// ----------------------------------------------------------------------------
module pqca_slot_table
  import pqca_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   we,
  input  idx_t   waddr,
  input  entry_t wdata,
  input  idx_t   raddr,
  output entry_t rdata
);

  entry_t               mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] written;
  entry_t               rd_entry;
  logic                 rd_written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_entry <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rd_written <= written[raddr];
    end
  end

  always_comb begin
    rdata = rd_entry;
    if (!rd_written) begin
      rdata.kind = KIND_NONE;
    end
  end

endmodule

FILE: hw/rtl/pqca_minmax_acc.sv
// ----------------------------------------------------------------------------
// pqca_minmax_acc
// Running bounds over a table scan: highest minimum, lowest maximum.
// ----------------------------------------------------------------------------
module pqca_minmax_acc
  import pqca_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    clear,
  input  logic    en,
  input  entry_t  entry,
  output bounds_t bounds
);

  bounds_t acc;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
    end else if (en) begin
      if (entry.kind == KIND_MIN) begin
        if (!acc.min_valid || entry.freq > acc.min_freq) begin
          acc.min_freq  <= entry.freq;
          acc.min_valid <= 1'b1;
        end
      end else if (entry.kind == KIND_MAX) begin
        if (!acc.max_valid || entry.freq < acc.max_freq) begin
          acc.max_freq  <= entry.freq;
          acc.max_valid <= 1'b1;
        end
      end
    end
  end

  assign bounds = acc;

endmodule

FILE: tb/pqca_bounds_checker.sv
// ----------------------------------------------------------------------------
// pqca_bounds_checker
// Watches both channels of the constraint aggregator, keeps its own copy of
// the slot table, predicts the bounds, conflict and check answer for every
// accepted request and compares each accepted result against them in order.
// ----------------------------------------------------------------------------
module pqca_bounds_checker
  import pqca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        mismatches,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  freq_t     slot_freq [NUM_SLOTS];
  kind_t     slot_kind [NUM_SLOTS];
  out_item_t awaited_bounds_q [$];
  out_item_t want;

  initial begin
    mismatches = 0;
    pending    = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_freq[i] = '0;
      slot_kind[i] = KIND_NONE;
    end
  end

  // Apply one request to the table, rescan it and form the result.
  function automatic out_item_t aggregate_request(in_item_t req);
    out_item_t rsp;
    freq_t     f;
    idx_t      s;
    rsp = '0;
    f   = req.frequency;
    s   = req.slot;
    if (int'(s) < NUM_SLOTS) begin
      case (req.action)
        ACT_ADD_MIN: begin
          slot_freq[s] = f;
          slot_kind[s] = KIND_MIN;
        end
        ACT_ADD_MAX: begin
          slot_freq[s] = f;
          slot_kind[s] = KIND_MAX;
        end
        ACT_UPDATE: if (slot_kind[s] != KIND_NONE) slot_freq[s] = f;
        ACT_REM_MIN: if (slot_kind[s] == KIND_MIN) slot_kind[s] = KIND_NONE;
        ACT_REM_MAX: if (slot_kind[s] == KIND_MAX) slot_kind[s] = KIND_NONE;
        default: ;
      endcase
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_kind[i] == KIND_MIN) begin
        if (!rsp.min_valid || slot_freq[i] > rsp.min_freq) begin
          rsp.min_freq  = slot_freq[i];
          rsp.min_valid = 1'b1;
        end
      end else if (slot_kind[i] == KIND_MAX) begin
        if (!rsp.max_valid || slot_freq[i] < rsp.max_freq) begin
          rsp.max_freq  = slot_freq[i];
          rsp.max_valid = 1'b1;
        end
      end
    end
    rsp.conflict = rsp.min_valid && rsp.max_valid && (rsp.min_freq > rsp.max_freq);
    if (req.action == ACT_CHECK) begin
      rsp.allowed = !rsp.conflict
                    && !(rsp.min_valid && f < rsp.min_freq)
                    && !(rsp.max_valid && f > rsp.max_freq);
    end
    return rsp;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) slot_kind[i] = KIND_NONE;
      awaited_bounds_q.delete();
    end else begin
      if (in_valid && !in_stall) awaited_bounds_q.push_back(aggregate_request(in_item));
      if (out_valid && !out_stall) begin
        if (awaited_bounds_q.size() == 0) begin
          $error("result item with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_bounds_q.pop_front();
          check_field("min_valid", 32'(want.min_valid), 32'(out_item.min_valid));
          check_field("min_freq",  want.min_freq,       out_item.min_freq);
          check_field("max_valid", 32'(want.max_valid), 32'(out_item.max_valid));
          check_field("max_freq",  want.max_freq,       out_item.max_freq);
          check_field("conflict",  32'(want.conflict),  32'(out_item.conflict));
          check_field("allowed",   32'(want.allowed),   32'(out_item.allowed));
        end
      end
    end
    pending = awaited_bounds_q.size();
  end

endmodule

FILE: tb/pstate_qos_constraint_aggregator_top_test.sv
// ----------------------------------------------------------------------------
// pstate_qos_constraint_aggregator_top_test
// Drives request items into the constraint aggregator: a directed pass over
// adds, moves, updates, removes and checks at the bounds, then random request
// mixes with random gaps and output stalls, a long output hold-off and a full
// drain. The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module pstate_qos_constraint_aggregator_top_test
  import pqca_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // action codes the block must ignore
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  localparam int CHUNKS      = 17;
  localparam int CHUNK_ITEMS = 50;
  localparam int BURST_CHUNK = 3;
  localparam int DRAIN_CHUNK = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        mismatches;
  int        pending;

  logic        calm = 1'b0;
  logic        burst = 1'b0;
  logic        long_hold_req = 1'b0;
  logic        long_hold_done = 1'b0;
  logic [31:0] freq_seen = 32'd1000;

  always #6 clk = ~clk;

  pstate_qos_constraint_aggregator_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  pqca_bounds_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Offer one request after a random gap and hold it until it is taken.
  task automatic offer_request(logic [2:0] act, logic [3:0] slot, logic [31:0] freq);
    in_item_t req;
    int       gap;
    logic     took;
    req.action    = act;
    req.slot      = slot;
    req.frequency = freq;
    gap = (calm || burst) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    freq_seen = freq;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  initial begin
    #7_200_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stall per item, one long hold-off on request.
  initial begin
    int   hold;
    logic took;
    wait (!rst);
    @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 19);
      if (long_hold_req && !long_hold_done) begin
        hold = 200;
        long_hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  initial begin
    int          pick;
    logic [2:0]  act;
    logic [31:0] freq;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: any frequency passes
    offer_request(ACT_CHECK,   4'd0,  32'h0000_0000);
    offer_request(ACT_CHECK,   4'd15, 32'hFFFF_FFFF);
    offer_request(ACT_ADD_MIN, 4'd0,  32'd1000);
    offer_request(ACT_ADD_MAX, 4'd15, 32'hFFFF_FFFF);
    offer_request(ACT_CHECK,   4'd7,  32'd999);
    offer_request(ACT_CHECK,   4'd7,  32'd1000);
    offer_request(ACT_CHECK,   4'd7,  32'hFFFF_FFFF);
    // re-add to the same set, then move the slot to the other set
    offer_request(ACT_ADD_MIN, 4'd3,  32'd0);
    offer_request(ACT_UPDATE,  4'd3,  32'd5000);
    offer_request(ACT_ADD_MIN, 4'd3,  32'd2000);
    offer_request(ACT_ADD_MAX, 4'd3,  32'd3000);
    offer_request(ACT_CHECK,   4'd3,  32'd3000);
    // equal bounds do not conflict
    offer_request(ACT_ADD_MIN, 4'd1,  32'd3000);
    offer_request(ACT_CHECK,   4'd1,  32'd3000);
    offer_request(ACT_ADD_MIN, 4'd2,  32'd4000);
    offer_request(ACT_CHECK,   4'd2,  32'd3500);
    // updates, removes and spare codes that must not touch the table, then removes that empty it
    offer_request(ACT_UPDATE,  4'd9,  32'd7);
    offer_request(ACT_REM_MIN, 4'd15, 32'd0);
    offer_request(ACT_REM_MAX, 4'd0,  32'd0);
    offer_request(ACT_SPARE_A, 4'd2,  32'd3500);
    offer_request(ACT_SPARE_B, 4'd15, 32'hFFFF_FFFF);
    offer_request(ACT_REM_MIN, 4'd2,  32'd0);
    offer_request(ACT_REM_MAX, 4'd3,  32'd0);
    offer_request(ACT_REM_MIN, 4'd0,  32'd0);
    offer_request(ACT_REM_MIN, 4'd1,  32'd0);
    offer_request(ACT_REM_MAX, 4'd15, 32'd0);

    for (int c = 0; c < CHUNKS; c++) begin
      burst = (c == BURST_CHUNK);
      long_hold_req = (c == BURST_CHUNK);
      calm = !burst && ($urandom_range(0, 3) == 0);
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)      act = ACT_ADD_MIN;
        else if (pick < 40) act = ACT_ADD_MAX;
        else if (pick < 52) act = ACT_UPDATE;
        else if (pick < 62) act = ACT_REM_MIN;
        else if (pick < 72) act = ACT_REM_MAX;
        else if (pick < 95) act = ACT_CHECK;
        else                act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
        // favor a few shared values so bounds collide, meet and cross
        case ($urandom_range(0, 9))
          0:       freq = 32'h0000_0000;
          1:       freq = 32'hFFFF_FFFF;
          2, 3, 4: freq = $urandom;
          5, 6, 7: freq = $urandom_range(1, 12) * 250;
          default: freq = freq_seen + $urandom_range(0, 2) - 1;
        endcase
        offer_request(act, 4'($urandom_range(0, 15)), freq);
      end
      if (c == DRAIN_CHUNK) wait_drained();
    end
    burst = 1'b0;
    long_hold_req = 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pqca_pkg.sv
hw/rtl/pqca_slot_table.sv
hw/rtl/pqca_minmax_acc.sv
hw/rtl/pstate_qos_constraint_aggregator_top.sv
tb/pqca_bounds_checker.sv
tb/pstate_qos_constraint_aggregator_top_test.sv
